// ----- rtl/core/prds_pkg.sv -----
`default_nettype none

package prds_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  // one transaction as it travels along the cell chain
  typedef struct packed {
    logic       valid;
    logic       op;
    logic [5:0] slot;
    logic [7:0] first;
    logic [7:0] span;
    logic [7:0] clip;
    logic [3:0] zone;
    logic [7:0] pix;
    logic       done;
    logic [7:0] result;
    logic       hit;
  } token_t;

endpackage

`default_nettype wire

// ----- rtl/core/prds_cell.sv -----
`default_nettype none

module prds_cell #(
  parameter int INDEX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic [6:0]      count,
  input  wire prds_pkg::token_t tin,
  output prds_pkg::token_t     tout
);

  logic [7:0] start;
  logic [7:0] length;
  logic [7:0] clip;

  logic              active;
  logic signed [10:0] first_s;
  logic signed [10:0] span_s;
  logic signed [10:0] end_s;
  logic signed [10:0] pix_s;
  logic signed [10:0] zone_s;
  logic signed [10:0] diff_s;
  logic signed [10:0] sum_s;
  prds_pkg::token_t  tnext;

  assign active  = 9'(INDEX) < {2'b00, count};
  assign first_s = {3'b000, start};
  assign span_s  = {{3{length[7]}}, length};
  assign end_s   = first_s + span_s;
  assign pix_s   = {3'b000, tin.pix};
  assign zone_s  = {7'b0000000, tin.zone};
  assign diff_s  = pix_s - zone_s;
  assign sum_s   = pix_s + zone_s;

  always_comb begin
    tnext = tin;
    if (tin.op == prds_pkg::OP_MAP && !tin.done && active) begin
      if (length[7]) begin
        if (pix_s <= first_s && pix_s > end_s) begin
          tnext.done = 1'b1;
          tnext.hit  = 1'b1;
          if (pix_s > zone_s && diff_s > end_s) begin
            tnext.result = diff_s[7:0];
          end else begin
            tnext.result = clip;
          end
        end
      end else if (pix_s >= first_s && pix_s < end_s) begin
        tnext.done   = 1'b1;
        tnext.hit    = 1'b1;
        tnext.result = (sum_s >= end_s) ? clip : sum_s[7:0];
      end
    end
  end

  // range entry held by this cell
  always_ff @(posedge clk) begin
    if (adv && tin.valid && tin.op == prds_pkg::OP_WRITE && 9'(tin.slot) == 9'(INDEX)) begin
      start  <= tin.first;
      length <= tin.span;
      clip   <= tin.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (adv) begin
      tout <= tnext;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/palette_range_depth_shade_unit.sv -----
`default_nettype none

// channel  | handshake                     | payload
// ---------+-------------------------------+-------------------------------------------
// item     | item_valid / item_stall       | op, entry_index, first_color, color_span,
//          |                               | clip_color, zone, pixel_index
// result   | result_valid / result_stall   | mapped_color, range_hit
// cfg      | cfg_valid / cfg_ready         | range_count
//
// One transaction enters per cycle unless stalled; each passes MAX_RANGES cells,
// one cell per cycle while not stalled; map results are read from the last cell.
// Writes ride the same chain and update their cell on the way, which keeps order with maps.
// Reset clears the chain valids and range_count; range entries are undefined until written.
// A stalled result freezes the whole chain and raises item_stall in the same cycle.

module palette_range_depth_shade_unit #(
  parameter int MAX_RANGES      = 64,
  parameter int ZONE_COUNT      = 16,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              op,
  input  wire logic [5:0]        entry_index,
  input  wire logic [7:0]        first_color,
  input  wire logic signed [7:0] color_span,
  input  wire logic [7:0]        clip_color,
  input  wire logic [3:0]        zone,
  input  wire logic [7:0]        pixel_index,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [7:0]             mapped_color,
  output logic                   range_hit,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [6:0]        range_count
);

  logic [6:0]       count;
  logic             adv;
  logic [3:0]       zone_sat;
  logic             pix_out;
  prds_pkg::token_t stage [MAX_RANGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      count <= range_count;
    end
  end

  assign zone_sat = ({5'd0, zone} > 9'(ZONE_COUNT - 1)) ? 4'(ZONE_COUNT - 1) : zone;
  assign pix_out  = {1'b0, pixel_index} >= 9'(PALETTE_ENTRIES);

  always_comb begin
    stage[0].valid  = item_valid;
    stage[0].op     = op;
    stage[0].slot   = entry_index;
    stage[0].first  = first_color;
    stage[0].span   = color_span;
    stage[0].clip   = clip_color;
    stage[0].zone   = zone_sat;
    stage[0].pix    = pixel_index;
    stage[0].done   = pix_out;
    stage[0].result = pixel_index;
    stage[0].hit    = 1'b0;
  end

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    prds_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .count(count),
      .tin  (stage[i]),
      .tout (stage[i+1])
    );
  end

  assign result_valid = stage[MAX_RANGES].valid && stage[MAX_RANGES].op == prds_pkg::OP_MAP;
  assign mapped_color = stage[MAX_RANGES].result;
  assign range_hit    = stage[MAX_RANGES].hit;
  assign adv          = !(result_valid && result_stall);
  assign item_stall   = !adv;

endmodule

`default_nettype wire

// ----- rtl/core/prds_checker.sv -----
`default_nettype none

module prds_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] mapped_color,
  input wire logic       range_hit,
  input wire logic       cfg_ready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(mapped_color) && $stable(range_hit))
    else $error("result payload changed while stalled");

  a_back_pressure: assert property (@(posedge clk)
    1'b1 |-> (item_stall == (result_valid && result_stall)))
    else $error("item stall does not follow result stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind palette_range_depth_shade_unit prds_checker u_prds_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .mapped_color(mapped_color),
  .range_hit   (range_hit),
  .cfg_ready   (cfg_ready)
);

`default_nettype wire
